// ----- sv/swsf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sliding-window sender with fast retransmit
// no dependencies; imported by sliding_window_sender_fast_retransmit and swsf_ctrl, not by swsf_ring

package swsf_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 8;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DUP_W    = 3;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // event kinds
  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 1'd1;

  localparam logic [CNT_W-1:0]  WINDOW_LEN_RST    = 4'd4;
  localparam logic [DUP_W-1:0]  DUP_THRESHOLD_RST = 3'd4;
  localparam logic [SEQ_W-1:0]  SEQ_RST           = 32'd1;

  typedef struct packed {
    logic [CNT_W-1:0] window_len;
    logic [DUP_W-1:0] dup_threshold;
  } swsf_cfg_t;

  typedef struct packed {
    logic              accepted;
    logic              window_full;
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [WORD_W-1:0] tx_payload;
    logic              tx_retransmit;
    logic              timer_stop;
    logic [SEQ_W-1:0]  timer_stop_seq;
    logic              timer_start;
    logic [SEQ_W-1:0]  timer_start_seq;
    logic [CNT_W-1:0]  in_flight;
  } swsf_result_t;

endpackage

// ----- sv/sliding_window_sender_fast_retransmit.sv -----
`timescale 1ns / 1ps
// sliding-window sender with cumulative acks, timeout and fast retransmit
// a held input beat is registered as a result when the result register is free or draining
// throughput: one event per cycle while out_stall_i does not hold the result register
// reset: window empty, sequence numbers at 1, window_len 4, dup_threshold 4
// ring contents are not cleared; only slots in flight are ever read
// depends on swsf_pkg, swsf_ctrl and swsf_ring

module sliding_window_sender_fast_retransmit #(
  parameter int unsigned WindowDepth = swsf_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned PayloadBits = swsf_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swsf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [swsf_pkg::OP_W-1:0]       op_i,
  input  logic [swsf_pkg::WORD_W-1:0]     payload_word_i,
  input  logic [swsf_pkg::SEQ_W-1:0]      ack_num_i,
  input  logic                            ack_checksum_ok_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic                            window_full_o,
  output logic                            tx_valid_o,
  output logic [swsf_pkg::SEQ_W-1:0]      tx_seq_o,
  output logic [swsf_pkg::WORD_W-1:0]     tx_payload_o,
  output logic                            tx_retransmit_o,
  output logic                            timer_stop_o,
  output logic [swsf_pkg::SEQ_W-1:0]      timer_stop_seq_o,
  output logic                            timer_start_o,
  output logic [swsf_pkg::SEQ_W-1:0]      timer_start_seq_o,
  output logic [swsf_pkg::CNT_W-1:0]      in_flight_o
);

  import swsf_pkg::*;

  localparam int unsigned IdxW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;

  swsf_cfg_t cfg_q;

  logic              in_valid_q;
  logic [OP_W-1:0]   op_q;
  logic [WORD_W-1:0] payload_q;
  logic [SEQ_W-1:0]  ack_q;
  logic              ack_ok_q;

  logic              out_valid_q;
  swsf_result_t      res_q;
  swsf_result_t      res_d;

  logic              fire;
  logic              in_take;

  logic                   ring_we;
  logic [IdxW-1:0]        ring_waddr;
  logic [PayloadBits-1:0] ring_wdata;
  logic [IdxW-1:0]        ring_raddr;
  logic [PayloadBits-1:0] ring_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len    <= WINDOW_LEN_RST;
      cfg_q.dup_threshold <= DUP_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LEN:    cfg_q.window_len    <= cfg_data_i;
        CFG_DUP_THRESHOLD: cfg_q.dup_threshold <= cfg_data_i[DUP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // the held beat moves on when the result register is free or being drained
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || fire) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= op_i;
      payload_q <= payload_word_i;
      ack_q     <= ack_num_i;
      ack_ok_q  <= ack_checksum_ok_i;
    end
  end

  swsf_ctrl #(
    .WindowDepth (WindowDepth),
    .PayloadBits (PayloadBits),
    .IdxW        (IdxW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .op_i              (op_q),
    .payload_word_i    (payload_q),
    .ack_num_i         (ack_q),
    .ack_checksum_ok_i (ack_ok_q),
    .cfg_i             (cfg_q),
    .head_payload_i    (ring_rdata),
    .ring_we_o         (ring_we),
    .ring_waddr_o      (ring_waddr),
    .ring_wdata_o      (ring_wdata),
    .ring_raddr_o      (ring_raddr),
    .res_o             (res_d)
  );

  swsf_ring #(
    .Depth    (WindowDepth),
    .DataBits (PayloadBits),
    .IdxW     (IdxW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = res_q.accepted;
  assign window_full_o     = res_q.window_full;
  assign tx_valid_o        = res_q.tx_valid;
  assign tx_seq_o          = res_q.tx_seq;
  assign tx_payload_o      = res_q.tx_payload;
  assign tx_retransmit_o   = res_q.tx_retransmit;
  assign timer_stop_o      = res_q.timer_stop;
  assign timer_stop_seq_o  = res_q.timer_stop_seq;
  assign timer_start_o     = res_q.timer_start;
  assign timer_start_seq_o = res_q.timer_start_seq;
  assign in_flight_o       = res_q.in_flight;

endmodule

// ----- sv/swsf_ring.sv -----
`timescale 1ns / 1ps
// payload ring: one write port, one registered read port with write forwarding
// depends on nothing outside its parameters

module swsf_ring #(
  parameter int unsigned Depth    = 8,
  parameter int unsigned DataBits = 64,
  parameter int unsigned IdxW     = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  logic [DataBits-1:0] mem [Depth];
  logic [DataBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/swsf_ctrl.sv -----
`timescale 1ns / 1ps
// window state and per-event decision logic of the sender
// depends on swsf_pkg; drives the payload ring write and head read ports

module swsf_ctrl #(
  parameter int unsigned WindowDepth = 8,
  parameter int unsigned PayloadBits = 64,
  parameter int unsigned IdxW        = (WindowDepth > 1) ? $clog2(WindowDepth) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [swsf_pkg::OP_W-1:0]     op_i,
  input  logic [swsf_pkg::WORD_W-1:0]   payload_word_i,
  input  logic [swsf_pkg::SEQ_W-1:0]    ack_num_i,
  input  logic                          ack_checksum_ok_i,
  input  swsf_pkg::swsf_cfg_t           cfg_i,
  input  logic [PayloadBits-1:0]        head_payload_i,
  output logic                          ring_we_o,
  output logic [IdxW-1:0]               ring_waddr_o,
  output logic [PayloadBits-1:0]        ring_wdata_o,
  output logic [IdxW-1:0]               ring_raddr_o,
  output swsf_pkg::swsf_result_t        res_o
);

  import swsf_pkg::*;

  localparam int unsigned SumW = ((IdxW > CNT_W) ? IdxW : CNT_W) + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(WindowDepth);
  localparam logic [7:0] Depth8 = 8'(WindowDepth);

  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic [CNT_W-1:0] flight_q, flight_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [DUP_W-1:0] dup_q, dup_d;

  logic [CNT_W-1:0] eff_win;
  logic [SumW-1:0]  slot_sum, slot_wrap;
  logic [SumW-1:0]  head_sum, head_wrap;
  logic [SEQ_W-1:0] ack_dist;
  logic [CNT_W-1:0] ack_step;
  logic             ack_usable;
  logic             send_ok;
  logic             resend;
  logic [DUP_W-1:0] dup_n;

  // window_len capped at the ring depth
  assign eff_win = ({4'd0, cfg_i.window_len} > Depth8) ? CNT_W'(WindowDepth)
                                                       : cfg_i.window_len;

  assign slot_sum  = SumW'(head_q) + SumW'(flight_q);
  assign slot_wrap = (slot_sum >= DepthS) ? (slot_sum - DepthS) : slot_sum;

  assign ack_dist   = ack_num_i - base_q;
  assign ack_step   = ack_dist[CNT_W-1:0];
  assign ack_usable = (flight_q != '0) && ack_checksum_ok_i
                      && (ack_dist <= SEQ_W'(flight_q));

  assign head_sum  = SumW'(head_q) + SumW'(ack_step);
  assign head_wrap = (head_sum >= DepthS) ? (head_sum - DepthS) : head_sum;

  assign send_ok = (flight_q < eff_win);

  always_comb begin
    res_o    = '0;
    base_d   = base_q;
    next_d   = next_q;
    flight_d = flight_q;
    head_d   = head_q;
    dup_d    = dup_q;
    dup_n    = dup_q;
    resend   = 1'b0;
    ring_we_o    = 1'b0;
    ring_waddr_o = slot_wrap[IdxW-1:0];
    ring_wdata_o = payload_word_i[PayloadBits-1:0];

    unique case (op_i)
      OP_SEND: begin
        if (send_ok) begin
          ring_we_o      = fire_i;
          res_o.accepted = 1'b1;
          res_o.tx_valid = 1'b1;
          res_o.tx_seq   = next_q;
          res_o.tx_payload = WORD_W'(payload_word_i[PayloadBits-1:0]);
          if (flight_q == '0) begin
            res_o.timer_start     = 1'b1;
            res_o.timer_start_seq = next_q;
          end
          flight_d = flight_q + CNT_W'(1);
          next_d   = next_q + SEQ_W'(1);
        end
      end
      OP_ACK: begin
        if (ack_usable) begin
          if (ack_dist == '0) begin
            dup_n = dup_q + DUP_W'(1);
            if (dup_n == cfg_i.dup_threshold) begin
              resend = 1'b1;
              dup_n  = '0;
            end
          end else begin
            dup_n = DUP_W'(1);
          end
          dup_d = dup_n;
          // a count of one slides the window, possibly by zero
          if (dup_n == DUP_W'(1)) begin
            res_o.timer_stop     = 1'b1;
            res_o.timer_stop_seq = base_q;
            base_d   = ack_num_i;
            head_d   = head_wrap[IdxW-1:0];
            flight_d = flight_q - ack_step;
            if (flight_d != '0) begin
              res_o.timer_start     = 1'b1;
              res_o.timer_start_seq = ack_num_i;
            end
          end
        end
      end
      OP_TIMEOUT: begin
        resend = (flight_q != '0);
      end
      default: begin
      end
    endcase

    if (resend) begin
      res_o.tx_valid        = 1'b1;
      res_o.tx_seq          = base_q;
      res_o.tx_payload      = WORD_W'(head_payload_i);
      res_o.tx_retransmit   = 1'b1;
      res_o.timer_stop      = 1'b1;
      res_o.timer_stop_seq  = base_q;
      res_o.timer_start     = 1'b1;
      res_o.timer_start_seq = base_q;
    end

    res_o.window_full = (flight_d >= eff_win);
    res_o.in_flight   = flight_d;
  end

  // head entry is read ahead so it is ready for the next beat
  assign ring_raddr_o = fire_i ? head_d : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= SEQ_RST;
      next_q   <= SEQ_RST;
      flight_q <= '0;
      head_q   <= '0;
      dup_q    <= '0;
    end else if (fire_i) begin
      base_q   <= base_d;
      next_q   <= next_d;
      flight_q <= flight_d;
      head_q   <= head_d;
      dup_q    <= dup_d;
    end
  end

  // in-flight count always matches the sequence span of the window
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q - base_q) == SEQ_W'(flight_q))
    else $error("window span differs from in-flight count");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'd0, flight_q} <= Depth8)
    else $error("in-flight count exceeds ring depth");

  a_send_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (op_i == OP_SEND) && send_ok |=> next_q == $past(next_q) + SEQ_W'(1))
    else $error("accepted send did not advance the sequence number");

  a_retx_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.tx_retransmit |-> res_o.tx_valid && (res_o.tx_seq == base_q))
    else $error("retransmit is not of the oldest packet");

endmodule
